@@ rtl/blm_pkg.sv @@
// ----------------------------------------------------------------------------
// blm_pkg
// Types, register indexes and constants shared by the battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned FILL_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_LEVEL_THR = 5;

  // Marks that no level has been shown since reset.
  localparam logic [LEVEL_W-1:0] NO_LEVEL  = 3'd7;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 3'd1;
  localparam logic [CODE_W-1:0]  COUNT_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL1_CODE    = 3'd0,
    REG_LEVEL2_CODE    = 3'd1,
    REG_LEVEL3_CODE    = 3'd2,
    REG_LEVEL4_CODE    = 3'd3,
    REG_LEVEL5_CODE    = 3'd4,
    REG_UNDERVOLT_CODE = 3'd5,
    REG_SHUTDOWN_TICKS = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_BLANK = 2'd2
  } action_e;

  typedef struct packed {
    logic [NUM_LEVEL_THR-1:0][CODE_W-1:0] level_code;
    logic [CODE_W-1:0]                    undervolt_code;
    logic [CODE_W-1:0]                    shutdown_ticks;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] last_level;
    logic               blink_phase;
    logic [CODE_W-1:0]  uv_count;
    logic               shutdown;
  } mon_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [FILL_W-1:0]  glyph_fill;
    action_e            display_action;
    logic               shutdown;
    logic               ignored;
  } result_t;

  // Glyph fill (7 bits): one more bar from the top for each level.
  function automatic logic [FILL_W-1:0] fill_of_level(input logic [LEVEL_W-1:0] lvl);
    logic [FILL_W-1:0] fill;
    case (lvl)
      3'd1:    fill = 7'd64;
      3'd2:    fill = 7'd96;
      3'd3:    fill = 7'd112;
      3'd4:    fill = 7'd120;
      3'd5:    fill = 7'd124;
      default: fill = 7'd0;
    endcase
    return fill;
  endfunction

endpackage

@@ rtl/blm_cfg.sv @@
// ----------------------------------------------------------------------------
// blm_cfg
// Configuration register file: thresholds and shutdown tick limit.
// ----------------------------------------------------------------------------
module blm_cfg import blm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CODE_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEVEL1_CODE:    cfg_d.level_code[0]  = cfg_data_i;
        REG_LEVEL2_CODE:    cfg_d.level_code[1]  = cfg_data_i;
        REG_LEVEL3_CODE:    cfg_d.level_code[2]  = cfg_data_i;
        REG_LEVEL4_CODE:    cfg_d.level_code[3]  = cfg_data_i;
        REG_LEVEL5_CODE:    cfg_d.level_code[4]  = cfg_data_i;
        REG_UNDERVOLT_CODE: cfg_d.undervolt_code = cfg_data_i;
        REG_SHUTDOWN_TICKS: cfg_d.shutdown_ticks = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_code[0]  <= 8'd171;
      cfg_q.level_code[1]  <= 8'd182;
      cfg_q.level_code[2]  <= 8'd193;
      cfg_q.level_code[3]  <= 8'd204;
      cfg_q.level_code[4]  <= 8'd215;
      cfg_q.undervolt_code <= 8'd155;
      cfg_q.shutdown_ticks <= 8'd15;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/blm_eval.sv @@
// ----------------------------------------------------------------------------
// blm_eval
// Combinational evaluation of one tick: level, glyph fill, display action,
// undervoltage count and the next monitor state.
// ----------------------------------------------------------------------------
module blm_eval import blm_pkg::*; (
  input  cfg_t              cfg_i,
  input  mon_state_t        state_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic              failed_i,
  output result_t           result_o,
  output mon_state_t        state_o
);

  logic [LEVEL_W-1:0] level;
  action_e            action;
  logic [CODE_W-1:0]  count_next;
  logic               shutdown_next;

  // Descending scan so that the lowest failing threshold wins, as a cascade.
  always_comb begin
    level = LEVEL_W'(NUM_LEVEL_THR);
    for (int k = NUM_LEVEL_THR - 1; k >= 0; k--) begin
      if (code_i < cfg_i.level_code[k]) begin
        level = LEVEL_W'(k);
      end
    end
  end

  always_comb begin
    if (code_i < cfg_i.undervolt_code) begin
      count_next = (state_i.uv_count == COUNT_MAX) ? state_i.uv_count
                                                    : state_i.uv_count + 8'd1;
    end else begin
      count_next = '0;
    end
    shutdown_next = state_i.shutdown | (count_next >= cfg_i.shutdown_ticks);
  end

  always_comb begin
    state_o = state_i;
    action  = ACT_NONE;
    if (!failed_i) begin
      if (level != state_i.last_level) begin
        action = ACT_DRAW;
      end
      // Low levels blink: the phase overrides the redraw decision.
      if (level <= LEVEL_ONE) begin
        action              = state_i.blink_phase ? ACT_BLANK : ACT_DRAW;
        state_o.blink_phase = ~state_i.blink_phase;
      end
      state_o.last_level = level;
      state_o.uv_count   = count_next;
      state_o.shutdown   = shutdown_next;
    end
  end

  always_comb begin
    if (failed_i) begin
      result_o.level          = '0;
      result_o.glyph_fill     = '0;
      result_o.display_action = ACT_NONE;
      result_o.shutdown       = state_i.shutdown;
      result_o.ignored        = 1'b1;
    end else begin
      result_o.level          = level;
      result_o.glyph_fill     = fill_of_level(level);
      result_o.display_action = action;
      result_o.shutdown       = shutdown_next;
      result_o.ignored        = 1'b0;
    end
  end

endmodule

@@ rtl/battery_level_monitor.sv @@
// ----------------------------------------------------------------------------
// battery_level_monitor
// Turns battery ADC ticks into a level, glyph fill, redraw/blink request
// and a sticky undervoltage shutdown flag.
// ----------------------------------------------------------------------------
// Usage:
//   Each tick arrives as one transfer on the slave stream: the ADC code in
//   tdata and the read-failure flag in tuser. Every tick gives exactly one
//   result transfer on the master stream, in order.
//   The thresholds and shutdown limit are to be written on the cfg port
//   while the block is idle; the block itself does not enforce this.
//   Writes to index 7 are dropped. A tick goes from the input register to
//   the result register. Throughput is one tick per cycle while results
//   are taken, set by the single evaluation stage that updates the level,
//   blink and undervoltage state as each tick moves to the result register.
//   While the receiver stalls, the pending result holds and one more tick
//   can wait in the input register; s_axis_tready then drops until the
//   result is taken.
//   Reset empties both registers, restores the register defaults, clears
//   the blink phase, count and shutdown flag, and forgets the last level so
//   the first good tick always asks for a draw.
// ----------------------------------------------------------------------------
module battery_level_monitor import blm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] battery_code
  input  logic                 s_axis_tuser,   // [0] read_failed
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [2:0] level, [9:3] glyph_fill, [11:10] display_action, [12] shutdown
  output logic [15:0]          m_axis_tdata,
  output logic                 m_axis_tuser,   // [0] ignored
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CODE_W-1:0]    cfg_data_i
);

  cfg_t              cfg;
  mon_state_t        state_q, state_d;
  result_t           result_d, result_q;
  logic              in_valid_q, in_valid_d;
  logic [CODE_W-1:0] in_code_q;
  logic              in_failed_q;
  logic              out_valid_q, out_valid_d;
  logic              in_accept, advance;

  blm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  blm_eval u_eval (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .code_i   (in_code_q),
    .failed_i (in_failed_q),
    .result_o (result_d),
    .state_o  (state_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.last_level  <= NO_LEVEL;
      state_q.blink_phase <= 1'b0;
      state_q.uv_count    <= '0;
      state_q.shutdown    <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_code_q   <= s_axis_tdata;
      in_failed_q <= s_axis_tuser;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, result_q.shutdown, result_q.display_action,
                          result_q.glyph_fill, result_q.level};
  assign m_axis_tuser  = result_q.ignored;

endmodule
